// File: rtl/core/tmsf_pkg.sv
// Package for the trimmed-mean slider filter: sizes, constants and the divide reciprocal.
package tmsf_pkg;

  localparam int WINDOW_LEN  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int PTR_BITS    = $clog2(WINDOW_LEN);
  localparam int CNT_BITS    = 4;

  localparam logic [CFG_BITS-1:0] CEILING_RESET = CFG_BITS'(1000);
  localparam logic [CNT_BITS-1:0] SETTLE_TARGET = CNT_BITS'(8);

  // Width of the trimmed sum: enough for WINDOW_LEN full-scale samples.
  localparam int TRIM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int DIVISOR   = WINDOW_LEN - 2;

  // Division by DIVISOR as a multiply by a rounded-up reciprocal and a shift.
  // The extra shift bits keep the quotient exact over the full trimmed range.
  localparam int DIV_SHIFT = TRIM_BITS + $clog2(DIVISOR);
  localparam int MULT_BITS = TRIM_BITS + 1;
  localparam longint unsigned DIV_MULT_L =
    ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MULT_BITS-1:0] DIV_MULT = DIV_MULT_L[MULT_BITS-1:0];
  localparam int PROD_BITS = TRIM_BITS + MULT_BITS;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TRIM_BITS-1:0]   trim_t;

endpackage

// File: rtl/core/trimmed_mean_slider_filter_top.sv
// Top level of the trimmed-mean slider filter: window ring, trimmed sum, divide and settle logic.

// Returns one result per accepted slider sample, in order; each result is registered in the
// window, trimmed-sum and output stages. An accepted sample overwrites the oldest of eight
// window entries. The next stage sums the window and drops the largest entry and the smaller
// of the smallest entry and cfg min ceiling (1000 after reset). The last stage divides by six
// with a reciprocal multiply, saturates, and updates the settle counter. filtered stays 0 and
// settled low until eight nonzero means have come in a row. The rate is one request per cycle
// while out_stall is low: each of the three register stages loads as soon as the stage after
// it frees. A stalled output holds its request while the two earlier stages keep filling.
module trimmed_mean_slider_filter_top
  import tmsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_BITS-1:0]    cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_BITS-1:0]    out_filtered,
  output logic                   out_settled
);

  logic [CFG_BITS-1:0] ceiling_r;
  sample_t             window_r [WINDOW_LEN];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic                s1_valid_r;
  logic                s2_valid_r;
  trim_t               trim_r;
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_filtered_r;
  logic                out_settled_r;
  logic [CNT_BITS-1:0] settle_cnt_r;
  logic [CNT_BITS-1:0] settle_cnt_nxt;

  logic                 in_accept;
  logic                 s2_load;
  logic                 s3_load;
  trim_t                trim_nxt;
  logic [PROD_BITS-1:0] prod;
  trim_t                quot;
  sample_t              mean;
  logic                 settled_nxt;

  assign s3_load   = s2_valid_r && (!out_valid_r || !out_stall);
  assign s2_load   = s1_valid_r && (!s2_valid_r || s3_load);
  // The window may change only once the previous snapshot has moved on.
  assign in_stall  = s1_valid_r && !s2_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= CEILING_RESET;
    end else if (cfg_wr_en) begin
      ceiling_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_r[i] <= '0;
      end
      wr_ptr_r <= '0;
    end else if (in_accept) begin
      window_r[wr_ptr_r] <= in_sample;
      if (wr_ptr_r == PTR_BITS'(WINDOW_LEN - 1)) begin
        wr_ptr_r <= '0;
      end else begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
    end
  end

  // Sum, largest entry and clamped smallest entry of the window snapshot.
  always_comb begin
    trim_t   sum;
    sample_t hi;
    sample_t lo;
    sum = '0;
    hi  = '0;
    lo  = sample_t'(ceiling_r);
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sum = sum + trim_t'(window_r[i]);
      if (window_r[i] > hi) begin
        hi = window_r[i];
      end
      if (window_r[i] < lo) begin
        lo = window_r[i];
      end
    end
    trim_nxt = sum - trim_t'(hi) - trim_t'(lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (s3_load) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      trim_r <= trim_nxt;
    end
  end

  assign prod = PROD_BITS'(trim_r) * PROD_BITS'(DIV_MULT);
  assign quot = trim_t'(prod[PROD_BITS-1:DIV_SHIFT]);
  assign mean = (quot > trim_t'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_BITS-1:0];

  always_comb begin
    if (mean == '0) begin
      settle_cnt_nxt = '0;
    end else if (settle_cnt_r < SETTLE_TARGET) begin
      settle_cnt_nxt = settle_cnt_r + CNT_BITS'(1);
    end else begin
      settle_cnt_nxt = settle_cnt_r;
    end
  end

  assign settled_nxt = settle_cnt_nxt >= SETTLE_TARGET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s3_load) begin
        settle_cnt_r <= settle_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_filtered_r <= settled_nxt ? mean[OUT_BITS-1:0] : '0;
      out_settled_r  <= settled_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_settled  = out_settled_r;

  // An accepted sample lands in the slot the pointer named.
  a_window_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> window_r[$past(wr_ptr_r)] == $past(in_sample))
    else $error("sample not written at the write pointer");

  // A settled result goes with a full settle count.
  a_settled_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_settled_r |-> settle_cnt_r == SETTLE_TARGET)
    else $error("settled flag without a full settle count");

  // An unsettled result carries zero.
  a_unsettled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_settled_r |-> out_filtered_r == '0)
    else $error("unsettled result is not zero");

  // The trimmed sum never exceeds seven full-scale samples.
  a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> trim_r <= trim_t'(SAMPLE_MAX) * trim_t'(WINDOW_LEN - 1))
    else $error("trimmed sum out of range");

endmodule
